// File: src/sbxk_pkg.sv
`default_nettype none

package sbxk_pkg;

    localparam int BYTE_W            = 8;
    localparam int SCORE_W           = 24;
    localparam int BEST_KEY_W        = 7;
    localparam int KEY_COUNT_DEFAULT = 128;
    localparam int LETTER_COUNT      = 26;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

    localparam logic [BYTE_W-1:0] W_ZERO  = 8'd10;
    localparam logic [BYTE_W-1:0] W_DIGIT = 8'd8;
    localparam logic [BYTE_W-1:0] W_SPACE = 8'd68;

    localparam logic [BYTE_W-1:0] LETTER_WEIGHT [LETTER_COUNT] = '{
        8'd82, 8'd16, 8'd28, 8'd43, 8'd128, 8'd22, 8'd20, 8'd61, 8'd71,
        8'd3,  8'd6,  8'd39, 8'd23, 8'd70,  8'd76, 8'd19, 8'd2,  8'd61,
        8'd62, 8'd91, 8'd28, 8'd9,  8'd23,  8'd3,  8'd19, 8'd1
    };

    typedef struct packed {
        logic last;
        logic clr;
    } sbxk_tag_t;

    function automatic logic [BYTE_W-1:0] char_weight(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] lc;
        logic [BYTE_W-1:0] w;
        lc = ch;
        w  = '0;
        if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
            lc = ch | CASE_BIT;
        end
        if (lc >= CH_LO_A && lc <= CH_LO_Z) begin
            w = LETTER_WEIGHT[5'(lc - CH_LO_A)];
        end else if (lc == CH_ZERO) begin
            w = W_ZERO;
        end else if (lc >= CH_ONE && lc <= CH_NINE) begin
            w = W_DIGIT;
        end else if (lc == CH_SPACE) begin
            w = W_SPACE;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: src/sbxk_acc.sv
`default_nettype none

module sbxk_acc #(
    parameter int KEY_COUNT = sbxk_pkg::KEY_COUNT_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [sbxk_pkg::BYTE_W-1:0]     in_byte,
    input  wire sbxk_pkg::sbxk_tag_t             in_tag,
    output logic      [sbxk_pkg::SCORE_W-1:0]    acc_scores [KEY_COUNT],
    output sbxk_pkg::sbxk_tag_t                  acc_tag
);
    import sbxk_pkg::*;

    logic      fresh_reg;
    sbxk_tag_t tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg <= 1'b1;
            tag_reg   <= '0;
        end else if (en) begin
            tag_reg.last <= in_valid && in_tag.last;
            tag_reg.clr  <= in_tag.clr;
            if (in_valid) begin
                fresh_reg <= in_tag.last;
            end
        end
    end

    assign acc_tag = tag_reg;

    genvar k;
    generate
        for (k = 0; k < KEY_COUNT; k++) begin : g_key
            logic [SCORE_W-1:0] acc_reg;
            logic [SCORE_W-1:0] acc_next;
            logic [SCORE_W-1:0] base;
            logic [SCORE_W:0]   sum;

            always_comb begin
                base     = fresh_reg ? '0 : acc_reg;
                sum      = {1'b0, base} + (SCORE_W+1)'(char_weight(in_byte ^ BYTE_W'(k)));
                acc_next = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
            end

            always_ff @(posedge aclk) begin
                if (en && in_valid) begin
                    acc_reg <= acc_next;
                end
            end

            assign acc_scores[k] = acc_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// File: src/sbxk_argmax.sv
`default_nettype none

module sbxk_argmax #(
    parameter int KEY_COUNT = sbxk_pkg::KEY_COUNT_DEFAULT,
    localparam int KEY_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic      [sbxk_pkg::SCORE_W-1:0] scores [KEY_COUNT],
    input  wire sbxk_pkg::sbxk_tag_t             tag_in,
    output logic      [sbxk_pkg::SCORE_W-1:0]    max_score,
    output logic      [KEY_W-1:0]                max_key,
    output sbxk_pkg::sbxk_tag_t                  tag_out
);
    import sbxk_pkg::*;

    localparam int LEAVES = 2 ** KEY_W;
    localparam int INNER  = LEAVES - 1;

    logic [SCORE_W-1:0] leaf_score [LEAVES];
    logic [SCORE_W-1:0] node_score [INNER];
    logic [KEY_W-1:0]   node_key   [INNER];
    sbxk_tag_t          tag_pipe   [KEY_W+1];

    genvar i, n, j;
    generate
        for (i = 0; i < LEAVES; i++) begin : g_leaf
            if (i < KEY_COUNT) begin : g_used
                assign leaf_score[i] = scores[i];
            end else begin : g_pad
                assign leaf_score[i] = '0;
            end
        end

        for (n = 0; n < INNER; n++) begin : g_node
            logic [SCORE_W-1:0] l_score;
            logic [SCORE_W-1:0] r_score;
            logic [KEY_W-1:0]   l_key;
            logic [KEY_W-1:0]   r_key;

            if (2 * n + 2 < INNER) begin : g_inner
                assign l_score = node_score[2*n+1];
                assign r_score = node_score[2*n+2];
                assign l_key   = node_key[2*n+1];
                assign r_key   = node_key[2*n+2];
            end else begin : g_bottom
                assign l_score = leaf_score[2*n+1-INNER];
                assign r_score = leaf_score[2*n+2-INNER];
                assign l_key   = KEY_W'(2*n+1-INNER);
                assign r_key   = KEY_W'(2*n+2-INNER);
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (l_score >= r_score) begin
                        node_score[n] <= l_score;
                        node_key[n]   <= l_key;
                    end else begin
                        node_score[n] <= r_score;
                        node_key[n]   <= r_key;
                    end
                end
            end
        end

        assign tag_pipe[0] = tag_in;
        for (j = 1; j <= KEY_W; j++) begin : g_tag
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    tag_pipe[j] <= '0;
                end else if (en) begin
                    tag_pipe[j] <= tag_pipe[j-1];
                end
            end
        end
    endgenerate

    assign max_score = node_score[0];
    assign max_key   = node_key[0];
    assign tag_out   = tag_pipe[KEY_W];

endmodule

`default_nettype wire

// File: src/single_byte_xor_key_search_unit.sv
`default_nettype none

// Single-byte XOR key search: takes one ciphertext byte per cycle and scores it
// against every candidate key at once in a bank of KEY_COUNT saturating 24-bit
// accumulators (English letter weights in thousandths). On the beat marked by
// s_tlast a pipelined compare tree picks the lowest key with the highest score,
// and the result (key, score, and a flag telling whether this message beats all
// earlier ones of its group) appears on the m_ side once it has passed the input
// register, the accumulators, the compare tree, the final stage and the output
// register. s_tuser on any byte of a message starts a new group. Throughput is
// one byte per cycle; s_tready drops only while a finished result sits in the
// final stage and the output register holds an untaken result.
module single_byte_xor_key_search_unit #(
    parameter int KEY_COUNT = sbxk_pkg::KEY_COUNT_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] cipher_byte
    input  wire logic        s_tlast,   // last_byte
    input  wire logic        s_tuser,   // group_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [6:0] best_key, [30:7] best_score, [31] zero
    output logic             m_tuser    // group_leader
);
    import sbxk_pkg::*;

    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic               en;
    logic               item_clr;

    logic               in_valid_reg;
    logic               clr_pend_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    sbxk_tag_t          in_tag_reg;

    logic [SCORE_W-1:0] acc_scores [KEY_COUNT];
    sbxk_tag_t          acc_tag;

    logic [SCORE_W-1:0] root_score;
    logic [KEY_W-1:0]   root_key;
    sbxk_tag_t          root_tag;

    logic [SCORE_W-1:0] group_best_reg;
    logic [SCORE_W-1:0] base_score;
    logic               leader;

    logic               fin_valid_reg;
    logic [SCORE_W-1:0] fin_score_reg;
    logic [KEY_W-1:0]   fin_key_reg;
    logic               fin_leader_reg;

    logic               m_valid_reg;
    logic [SCORE_W-1:0] m_score_reg;
    logic [BEST_KEY_W-1:0] m_key_reg;
    logic               m_leader_reg;
    logic               out_load;

    // stall only when the final stage cannot hand its result over
    assign en       = !(fin_valid_reg && m_valid_reg && !m_tready);
    assign s_tready = en;
    assign item_clr = s_tuser || clr_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            clr_pend_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
            if (s_tvalid) begin
                clr_pend_reg <= s_tlast ? 1'b0 : item_clr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_tvalid) begin
            in_byte_reg     <= s_tdata;
            in_tag_reg.last <= s_tlast;
            in_tag_reg.clr  <= item_clr;
        end
    end

    sbxk_acc #(
        .KEY_COUNT (KEY_COUNT)
    ) u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (in_valid_reg),
        .in_byte    (in_byte_reg),
        .in_tag     (in_tag_reg),
        .acc_scores (acc_scores),
        .acc_tag    (acc_tag)
    );

    sbxk_argmax #(
        .KEY_COUNT (KEY_COUNT)
    ) u_argmax (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .scores    (acc_scores),
        .tag_in    (acc_tag),
        .max_score (root_score),
        .max_key   (root_key),
        .tag_out   (root_tag)
    );

    assign base_score = root_tag.clr ? '0 : group_best_reg;
    assign leader     = root_score > base_score;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg  <= 1'b0;
            group_best_reg <= '0;
        end else if (en) begin
            fin_valid_reg <= root_tag.last;
            if (root_tag.last) begin
                group_best_reg <= leader ? root_score : base_score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && root_tag.last) begin
            fin_score_reg  <= root_score;
            fin_key_reg    <= root_key;
            fin_leader_reg <= leader;
        end
    end

    assign out_load = fin_valid_reg && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_score_reg  <= fin_score_reg;
            m_key_reg    <= BEST_KEY_W'(fin_key_reg);
            m_leader_reg <= fin_leader_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_score_reg, m_key_reg};
    assign m_tuser  = m_leader_reg;

    a_leader_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[30:7] != '0)
        else $error("leader flagged with zero score");

    a_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30:7] == '0 |-> m_tdata[6:0] == '0)
        else $error("zero score with nonzero key");

    a_group_best: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && fin_leader_reg |-> group_best_reg == fin_score_reg)
        else $error("group best not updated by leader");

endmodule

`default_nettype wire

// File: test/tb_single_byte_xor_key_search_unit.sv
module tb_single_byte_xor_key_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sbxk_pkg::*;

    localparam int KEYS = KEY_COUNT_DEFAULT;

    typedef struct packed {
        logic [BYTE_W-1:0] cipher;
        logic              last;
        logic              gstart;
    } cipher_beat_t;

    typedef struct packed {
        logic [BEST_KEY_W-1:0] key;
        logic [SCORE_W-1:0]    score;
        logic                  leader;
    } key_verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    cipher_beat_t       pending_beats[$];
    key_verdict_t       expected_verdicts[$];
    logic [SCORE_W-1:0] key_tally[KEYS];
    logic [SCORE_W-1:0] group_peak;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned hold_left      = 0;
    bit          hold_req       = 1'b0;
    bit          in_taken       = 1'b0;

    single_byte_xor_key_search_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] english_weight(input logic [7:0] ch);
        logic [7:0] c;
        c = (ch >= "A" && ch <= "Z") ? (ch | 8'h20) : ch;
        case (c)
            "a": return 8'd82;
            "b": return 8'd16;
            "c": return 8'd28;
            "d": return 8'd43;
            "e": return 8'd128;
            "f": return 8'd22;
            "g": return 8'd20;
            "h": return 8'd61;
            "i": return 8'd71;
            "j": return 8'd3;
            "k": return 8'd6;
            "l": return 8'd39;
            "m": return 8'd23;
            "n": return 8'd70;
            "o": return 8'd76;
            "p": return 8'd19;
            "q": return 8'd2;
            "r": return 8'd61;
            "s": return 8'd62;
            "t": return 8'd91;
            "u": return 8'd28;
            "v": return 8'd9;
            "w": return 8'd23;
            "x": return 8'd3;
            "y": return 8'd19;
            "z": return 8'd1;
            "0": return 8'd10;
            " ": return 8'd68;
            default: return (c >= "1" && c <= "9") ? 8'd8 : 8'd0;
        endcase
    endfunction

    task automatic absorb_beat(input cipher_beat_t b);
        logic [SCORE_W:0] sum;
        key_verdict_t     v;
        int unsigned      k;
        if (b.gstart) begin
            group_peak = '0;
        end
        for (k = 0; k < KEYS; k++) begin
            sum = {1'b0, key_tally[k]} + english_weight(b.cipher ^ 8'(k));
            key_tally[k] = (sum > SCORE_MAX) ? SCORE_MAX : sum[SCORE_W-1:0];
        end
        if (b.last) begin
            v = '0;
            for (k = 0; k < KEYS; k++) begin
                if (key_tally[k] > v.score) begin
                    v.score = key_tally[k];
                    v.key   = k[BEST_KEY_W-1:0];
                end
            end
            v.leader = v.score > group_peak;
            if (v.leader) begin
                group_peak = v.score;
            end
            expected_verdicts = {expected_verdicts, v};
            for (k = 0; k < KEYS; k++) begin
                key_tally[k] = '0;
            end
        end
    endtask

    task automatic add_beat(input logic [7:0] cipher, input bit last, input bit gstart);
        cipher_beat_t b;
        b.cipher = cipher;
        b.last   = last;
        b.gstart = gstart;
        pending_beats = {pending_beats, b};
    endtask

    function automatic logic [7:0] english_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 8'("a" + $urandom_range(25));
        if (r < 70) return 8'("A" + $urandom_range(25));
        if (r < 85) return " ";
        if (r < 90) return 8'("0" + $urandom_range(9));
        return 8'($urandom_range(127));
    endfunction

    task automatic queue_message(input int unsigned len, input bit noise);
        logic [7:0]  key;
        logic [7:0]  plain;
        int unsigned gpos;
        bit          gflag;
        int unsigned i;
        key   = 8'($urandom_range(255));
        gflag = $urandom_range(99) < 15;
        gpos  = ($urandom_range(99) < 30) ? $urandom_range(len - 1) : 0;
        for (i = 0; i < len; i++) begin
            plain = noise ? 8'($urandom_range(255)) : english_char();
            add_beat(noise ? plain : (plain ^ key), i == len - 1, gflag && i == gpos);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || expected_verdicts.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left <= 400;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin : drive_beats
        cipher_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_beats.pop_front();
                s_tdata  <= nxt.cipher;
                s_tlast  <= nxt.last;
                s_tuser  <= nxt.gstart;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end

    always @(posedge aclk) begin : watch_beats
        cipher_beat_t got;
        key_verdict_t want;
        in_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            got.cipher = s_tdata;
            got.last   = s_tlast;
            got.gstart = s_tuser;
            absorb_beat(got);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                $error("result with nothing expected: best_key %0d best_score %0d",
                       m_tdata[6:0], m_tdata[30:7]);
                fail_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[6:0] != want.key) begin
                    $error("best_key expected %0d actual %0d", want.key, m_tdata[6:0]);
                    fail_count++;
                end
                if (m_tdata[30:7] != want.score) begin
                    $error("best_score expected %0d actual %0d", want.score, m_tdata[30:7]);
                    fail_count++;
                end
                if (m_tuser != want.leader) begin
                    $error("group_leader expected %0d actual %0d", want.leader, m_tuser);
                    fail_count++;
                end
                if (m_tdata[31] !== 1'b0) begin
                    $error("m_tdata pad expected 0 actual %0d", m_tdata[31]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : run_test
        int unsigned phase;
        int unsigned queued;
        int unsigned len;
        int unsigned i;
        group_peak = '0;
        for (i = 0; i < KEYS; i++) begin
            key_tally[i] = '0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_beat(8'h00, 1'b1, 1'b1);
        add_beat(8'hFF, 1'b1, 1'b0);
        add_beat(8'h80, 1'b1, 1'b1);
        add_beat(8'h41, 1'b1, 1'b1);
        add_beat(8'h41, 1'b1, 1'b0);
        add_beat(8'h7F, 1'b0, 1'b0);
        add_beat(8'h20, 1'b0, 1'b0);
        add_beat(8'h30, 1'b0, 1'b0);
        add_beat(8'h31, 1'b0, 1'b0);
        add_beat(8'h39, 1'b1, 1'b0);
        add_beat("H" ^ 8'h5A, 1'b0, 1'b1);
        add_beat("e" ^ 8'h5A, 1'b0, 1'b0);
        add_beat("l" ^ 8'h5A, 1'b0, 1'b0);
        add_beat("l" ^ 8'h5A, 1'b0, 1'b0);
        add_beat("o" ^ 8'h5A, 1'b1, 1'b0);
        add_beat(8'h01, 1'b0, 1'b0);
        add_beat(8'hFE, 1'b1, 1'b0);
        add_beat(8'hC5, 1'b0, 1'b1);
        add_beat(8'h65, 1'b1, 1'b0);
        wait_drained();

        // hold off the receiver while single-beat messages pile up behind it
        @(negedge aclk);
        hold_req = 1'b1;
        @(negedge aclk);
        hold_req = 1'b0;
        for (i = 0; i < 40; i++) begin
            add_beat(8'($urandom_range(255)), 1'b1, $urandom_range(9) == 0);
        end
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            queued = 0;
            while (queued < 140) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(12, 1);
                queue_message(len, $urandom_range(99) < 15);
                queued += len;
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/sbxk_pkg.sv
src/sbxk_acc.sv
src/sbxk_argmax.sv
src/single_byte_xor_key_search_unit.sv
test/tb_single_byte_xor_key_search_unit.sv
